// File: hw/rtl/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared types and constants for the least common multiple core: the step
// codes that the sequencer hands to the datapath, and the datapath status.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int OPERAND_BITS_DEFAULT = 16;
    localparam int MULTIPLE_BITS        = 32;

    // One code per kind of step the shared adder performs.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_GCD,
        OP_DIV,
        OP_MUL
    } lcm_op_t;

    typedef struct packed {
        logic any_zero;   // an incoming operand is zero
        logic gcd_done;   // both gcd operands odd and equal
    } lcm_status_t;

endpackage

// File: hw/rtl/lcm_dp.sv
// ----------------------------------------------------------------------------
// lcm_dp
// Datapath around one shared add/subtract unit: binary gcd steps, a restoring
// divide of the shifted first operand by the odd gcd part, and a shift-add
// multiply by the second operand. One step per cycle, chosen by op.
// ----------------------------------------------------------------------------
module lcm_dp
    import lcm_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  lcm_op_t                     op,
    input  logic [OPERAND_BITS-1:0]     first_operand,
    input  logic [OPERAND_BITS-1:0]     second_operand,
    output lcm_status_t                 status,
    output logic [2*OPERAND_BITS-1:0]   product
);

    localparam int W = OPERAND_BITS;

    logic [W-1:0]   x_reg, x_next;
    logic [W-1:0]   y_reg, y_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [2*W-1:0] acc_reg, acc_next;

    // shared unit
    logic [W:0]     opa;
    logic [W:0]     opb;
    logic           sub;
    logic [W+1:0]   res;
    logic           borrow;
    logic           gcd_equal;

    always_comb
    begin
        opa = '0;
        opb = '0;
        sub = 1'b0;
        unique case (op)
            OP_GCD:
            begin
                opa = {1'b0, x_reg};
                opb = {1'b0, y_reg};
                sub = 1'b1;
            end
            OP_DIV:
            begin
                // partial remainder with the next dividend bit shifted in
                opa = acc_reg[2*W-1:W-1];
                opb = {1'b0, x_reg};
                sub = 1'b1;
            end
            OP_MUL:
            begin
                opa = {1'b0, acc_reg[2*W-1:W]};
                opb = acc_reg[0] ? {1'b0, b_reg} : '0;
            end
            OP_HOLD, OP_LOAD:
            begin
                opa = '0;
                opb = '0;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        res    = sub ? ({1'b0, opa} - {1'b0, opb}) : ({1'b0, opa} + {1'b0, opb});
        borrow = res[W+1];
    end

    assign gcd_equal       = x_reg[0] && y_reg[0] && (res == '0);
    assign status.gcd_done = (op == OP_GCD) && gcd_equal;
    assign status.any_zero = (first_operand == '0) || (second_operand == '0);
    assign product         = acc_reg;

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        unique case (op)
            OP_LOAD:
            begin
                x_next = first_operand;
                y_next = second_operand;
                a_next = first_operand;
                b_next = second_operand;
            end
            OP_GCD:
            begin
                priority if (!x_reg[0] && !y_reg[0])
                begin
                    // common factor of two: drop it from the dividend as well
                    x_next = {1'b0, x_reg[W-1:1]};
                    y_next = {1'b0, y_reg[W-1:1]};
                    a_next = {1'b0, a_reg[W-1:1]};
                end
                else if (!x_reg[0])
                begin
                    x_next = {1'b0, x_reg[W-1:1]};
                end
                else if (!y_reg[0])
                begin
                    y_next = {1'b0, y_reg[W-1:1]};
                end
                else if (gcd_equal)
                begin
                    acc_next = {{W{1'b0}}, a_reg};
                end
                else if (!borrow)
                begin
                    x_next = res[W-1:0];
                end
                else
                begin
                    // swap so the next cycle subtracts the smaller one
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            OP_DIV:
            begin
                acc_next = {(borrow ? acc_reg[2*W-2:W-1] : res[W-1:0]),
                            acc_reg[W-2:0], !borrow};
            end
            OP_MUL:
            begin
                acc_next = {res[W:0], acc_reg[W-1:1]};
            end
            OP_HOLD:
            begin
                acc_next = acc_reg;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

// File: hw/rtl/lcm_seq.sv
// ----------------------------------------------------------------------------
// lcm_seq
// Sequencer for the core: takes a word, steps the datapath through the gcd, divide and
// multiply phases unless an operand is zero, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module lcm_seq
    import lcm_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [MULTIPLE_BITS-1:0]    out_multiple,
    output logic                        out_invalid,
    output lcm_op_t                     op,
    input  lcm_status_t                 status,
    input  logic [2*OPERAND_BITS-1:0]   product
);

    localparam int CNT_BITS = $clog2(OPERAND_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [CNT_BITS-1:0]        cnt_reg;
    logic                       invalid_reg;
    logic                       out_valid_reg;
    logic [MULTIPLE_BITS-1:0]   out_multiple_reg;
    logic                       out_invalid_reg;
    logic                       last_step;
    logic                       out_free;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_multiple = out_multiple_reg;
    assign out_invalid  = out_invalid_reg;
    assign last_step    = (cnt_reg == CNT_BITS'(OPERAND_BITS - 1));
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: op = in_valid ? OP_LOAD : OP_HOLD;
            ST_GCD:  op = OP_GCD;
            ST_DIV:  op = OP_DIV;
            ST_MUL:  op = OP_MUL;
            ST_DONE: op = OP_HOLD;
            default: op = OP_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            invalid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_multiple_reg <= '0;
            out_invalid_reg  <= 1'b0;
        end
        else
        begin
            // load a new result word, or hold the current one until it is taken
            out_valid_reg <= ((state_reg == ST_DONE) && out_free) ||
                             (out_valid_reg && !out_ready);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        invalid_reg <= status.any_zero;
                        cnt_reg     <= '0;
                        state_reg   <= status.any_zero ? ST_DONE : ST_GCD;
                    end
                end
                ST_GCD:
                begin
                    if (status.gcd_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= last_step ? '0 : cnt_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    cnt_reg <= last_step ? '0 : cnt_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_multiple_reg <= invalid_reg ? '0 : MULTIPLE_BITS'(product);
                        out_invalid_reg  <= invalid_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/lcm_two_operands_core.sv
// Steps: a load, binary gcd steps, OPERAND_BITS divide steps and OPERAND_BITS multiply
// steps, then a move into the output register once that register is free.
// A word with a zero operand skips the gcd, divide and multiply steps.
// No new word is taken until the result is in the output register: the single shared
// add/subtract unit does every gcd, divide and multiply step.
// Reset (rst_n low, asynchronous) returns to idle and empties the output register.
// ----------------------------------------------------------------------------
// lcm_two_operands_core
// Least common multiple of two unsigned operands, computed as
// (first / gcd) * second with a flag for a zero operand.
// ----------------------------------------------------------------------------
module lcm_two_operands_core
    import lcm_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // first_operand, second_operand
    input  logic [((2*OPERAND_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // multiple
    output logic [MULTIPLE_BITS-1:0]                m_tdata,
    // invalid
    output logic                                    m_tuser
);

    logic [OPERAND_BITS-1:0]    first_operand;
    logic [OPERAND_BITS-1:0]    second_operand;
    lcm_op_t                    op;
    lcm_status_t                status;
    logic [2*OPERAND_BITS-1:0]  product;

    assign first_operand  = s_tdata[OPERAND_BITS-1:0];
    assign second_operand = s_tdata[2*OPERAND_BITS-1:OPERAND_BITS];

    lcm_seq #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_multiple (m_tdata),
        .out_invalid  (m_tuser),
        .op           (op),
        .status       (status),
        .product      (product)
    );

    lcm_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .clk            (clk),
        .op             (op),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .status         (status),
        .product        (product)
    );

`ifndef ASSERT_OFF
    // an operand load happens only on an accepted word
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_LOAD) |-> (s_tvalid && s_tready))
        else $error("operand load without an accepted word");

    // one word at a time: ready drops right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after accepting a word");

    // a flagged result carries zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("invalid result with nonzero multiple");
`endif

endmodule

// File: test/lcm_two_operands_checker.sv
// ----------------------------------------------------------------------------
// lcm_two_operands_checker
// Watches both stream channels of the LCM core. For every operand word it
// accepts, it predicts the least common multiple and the zero-operand flag.
// Each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lcm_two_operands_checker
    import lcm_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // first_operand, second_operand
    input  logic [((2*OPERAND_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // multiple
    input  logic [MULTIPLE_BITS-1:0]            m_tdata,
    // invalid
    input  logic                                m_tuser,
    output int                                  error_count,
    output int                                  outstanding,
    output int                                  checked_count,
    output int                                  invalid_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [OPERAND_BITS-1:0] operand_t;

    typedef struct packed {
        logic [MULTIPLE_BITS-1:0] multiple;
        logic                     invalid;
    } lcm_result_t;

    lcm_result_t pending_lcms[$];

    initial
    begin
        error_count   = 0;
        outstanding   = 0;
        checked_count = 0;
        invalid_count = 0;
    end

    function automatic lcm_result_t predict_lcm(input operand_t first_op,
                                                input operand_t second_op);
        lcm_result_t     res;
        logic [63:0]     x;
        logic [63:0]     y;
        logic [63:0]     rem;
        logic [63:0]     product;
        x = 64'(first_op);
        y = 64'(second_op);
        if (x == 0 || y == 0)
        begin
            res.multiple = '0;
            res.invalid  = 1'b1;
            return res;
        end
        // Euclid on a copy; x ends as the gcd
        while (y != 0)
        begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        product      = (64'(first_op) / x) * 64'(second_op);
        res.multiple = product[MULTIPLE_BITS-1:0];
        res.invalid  = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin : watch_channels
        lcm_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_lcms.push_back(predict_lcm(s_tdata[OPERAND_BITS-1:0],
                                                   s_tdata[2*OPERAND_BITS-1:OPERAND_BITS]));
            if (m_tvalid && m_tready)
            begin
                if (pending_lcms.size() == 0)
                    report_mismatch($sformatf("result word %h/%b with nothing pending",
                                              m_tdata, m_tuser));
                else
                begin
                    want = pending_lcms.pop_front();
                    checked_count++;
                    if (want.invalid)
                        invalid_count++;
                    if (m_tdata !== want.multiple)
                        report_mismatch($sformatf("word %0d: multiple %0d, want %0d",
                                                  checked_count, m_tdata, want.multiple));
                    if (m_tuser !== want.invalid)
                        report_mismatch($sformatf("word %0d: invalid %b, want %b",
                                                  checked_count, m_tuser, want.invalid));
                end
            end
            outstanding = pending_lcms.size();
        end
    end

endmodule

// File: test/lcm_two_operands_core_test.sv
// ----------------------------------------------------------------------------
// lcm_two_operands_core_test
// Drives operand pairs into the LCM core: a directed set of zero, extreme,
// equal and dividing operands, then random pairs in three idle patterns.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module lcm_two_operands_core_test;
    import lcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPERAND_BITS  = OPERAND_BITS_DEFAULT;
    localparam int DATA_BITS     = ((2*OPERAND_BITS+7)/8)*8;
    localparam int PHASE_WORDS   = 533;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [DATA_BITS-1:0]     s_tdata  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [MULTIPLE_BITS-1:0] m_tdata;
    logic                     m_tuser;

    int error_count;
    int outstanding;
    int checked_count;
    int invalid_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    lcm_two_operands_core #(.OPERAND_BITS(OPERAND_BITS)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lcm_two_operands_checker #(.OPERAND_BITS(OPERAND_BITS)) u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .invalid_count (invalid_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still pending",
                     cycle_count, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold the word until the core takes it; valid stays high into the next word.
    task automatic send_operands(input logic [OPERAND_BITS-1:0] first_op,
                                 input logic [OPERAND_BITS-1:0] second_op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_BITS'({second_op, first_op});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random_pair();
        int          pick;
        int          g;
        int          k;
        logic [15:0] first_op;
        logic [15:0] second_op;
        pick      = $urandom_range(99);
        first_op  = 16'($urandom);
        second_op = 16'($urandom);
        if (pick < 5)
        begin
            // one or both operands zero
            if ($urandom_range(1))
                first_op = '0;
            if ($urandom_range(1) || first_op != 0)
                second_op = '0;
        end
        else if (pick < 15)
            second_op = (first_op == 0) ? 16'd1 : first_op;
        else if (pick < 30)
        begin
            // one operand divides the other
            g         = $urandom_range(1, 255);
            k         = $urandom_range(1, 65535 / g);
            first_op  = 16'(g);
            second_op = 16'(g * k);
            if ($urandom_range(1))
                {first_op, second_op} = {second_op, first_op};
        end
        else if (pick < 50)
        begin
            // shared factor of 1 to 255
            g         = $urandom_range(1, 255);
            first_op  = 16'(g * $urandom_range(1, 65535 / g));
            second_op = 16'(g * $urandom_range(1, 65535 / g));
        end
        else if (pick < 75)
        begin
            first_op  = first_op >> $urandom_range(15);
            second_op = second_op >> $urandom_range(15);
            if (first_op == 0)
                first_op = 16'd1;
            if (second_op == 0)
                second_op = 16'd1;
        end
        send_operands(first_op, second_op);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct <= 48;
        // zero operands
        send_operands(16'h0000, 16'h0000);
        send_operands(16'h0000, 16'h0005);
        send_operands(16'h0007, 16'h0000);
        send_operands(16'h0000, 16'hFFFF);
        send_operands(16'hFFFF, 16'h0000);
        // extremes
        send_operands(16'h0001, 16'h0001);
        send_operands(16'h0001, 16'hFFFF);
        send_operands(16'hFFFF, 16'h0001);
        send_operands(16'hFFFF, 16'hFFFF);
        send_operands(16'hFFFF, 16'hFFFE);
        send_operands(16'hFFFE, 16'hFFFF);
        send_operands(16'h8000, 16'h8000);
        send_operands(16'h8000, 16'h0001);
        send_operands(16'hAAAA, 16'h5555);
        send_operands(16'd65521, 16'd65534);
        // equal, dividing and common-factor operands
        send_operands(16'd7, 16'd7);
        send_operands(16'd6, 16'd3);
        send_operands(16'd3, 16'd6);
        send_operands(16'd1000, 16'd10);
        send_operands(16'd12, 16'd18);
        send_operands(16'd18, 16'd12);

        repeat (PHASE_WORDS) send_random_pair();
        send_idle_pct = 48;
        recv_idle_pct <= 38;
        repeat (PHASE_WORDS) send_random_pair();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        repeat (PHASE_WORDS) send_random_pair();
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d LCM results, %0d of them with a zero operand,", checked_count,
                 invalid_count);
        $display("across sender/receiver stalls both ways and a stall-free stretch.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lcm_pkg.sv
hw/rtl/lcm_dp.sv
hw/rtl/lcm_seq.sv
hw/rtl/lcm_two_operands_core.sv
test/lcm_two_operands_checker.sv
test/lcm_two_operands_core_test.sv
